// ===== rtl/irst_pkg.sv =====
// ----------------------------------------------------------------------------
// irst_pkg
// Shared types and constants of the IR synced strobe timer.
// ----------------------------------------------------------------------------
package irst_pkg;

  // width of the strobe counter, pulse counter, period and mismatch counter
  localparam int COUNT_WIDTH = 16;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CEIL_W      = 16;

  // reset values of the registers and state
  localparam int DEBOUNCE_RESET = 10;
  localparam int FRAMES_RESET   = 6;
  localparam int OFFSET_RESET   = 2;
  localparam int ON_DUTY_RESET  = 4;
  localparam int CEILING_RESET  = 65534;
  localparam int PERIOD_RESET   = 3000;

  // iterative divider: quotient bits resolved per cycle
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS      = (COUNT_WIDTH + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int DIV_DW         = DIV_STEPS * DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

  // compare width for the counter ceiling test
  localparam int CMP_W = (COUNT_WIDTH > CEIL_W) ? COUNT_WIDTH : CEIL_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEBOUNCE_LIMIT  = 3'd0,
    CFG_FRAMES_PER_EVT  = 3'd1,
    CFG_PERIOD_OFFSET   = 3'd2,
    CFG_ON_DUTY_TICKS   = 3'd3,
    CFG_COUNTER_CEILING = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    DIV_QUOT = 2'd0,
    DIV_ON   = 2'd1,
    DIV_PER  = 2'd2
  } div_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_Q,
    ST_WAIT_Q,
    ST_START_ON,
    ST_WAIT_ON,
    ST_START_PER,
    ST_WAIT_PER,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    tick;
    logic    div_start;
    div_op_t div_op;
    logic    div_capture;
    logic    finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_quot;
    logic on_div_nz;
    logic period_nz;
    logic div_done;
  } status_t;

endpackage

// ===== rtl/irst_divider.sv =====
// ----------------------------------------------------------------------------
// irst_divider
// Iterative restoring divider, DIV_RADIX_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module irst_divider
  import irst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [COUNT_WIDTH-1:0] dividend,
  input  logic [COUNT_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [COUNT_WIDTH-1:0] quotient,
  output logic [COUNT_WIDTH-1:0] remainder
);

  logic                   busy;
  logic [DIV_CNT_W-1:0]   steps_left;
  logic [COUNT_WIDTH-1:0] rem;
  logic [DIV_DW-1:0]      quo;
  logic [COUNT_WIDTH-1:0] dsor;
  logic [COUNT_WIDTH-1:0] rem_next;
  logic [DIV_DW-1:0]      quo_next;

  // DIV_RADIX_BITS compare and subtract steps per cycle
  always_comb begin
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH-1:0] r;
    logic [DIV_DW-1:0]      q;
    r = rem;
    q = quo;
    trial = '0;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      trial = {r, q[DIV_DW-1]};
      q = {q[DIV_DW-2:0], 1'b0};
      if (trial >= {1'b0, dsor}) begin
        trial = trial - {1'b0, dsor};
        q[0] = 1'b1;
      end
      r = trial[COUNT_WIDTH-1:0];
    end
    rem_next = r;
    quo_next = q;
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        steps_left <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= DIV_DW'(dividend);
      dsor <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient  = quo[COUNT_WIDTH-1:0];
  assign remainder = rem;

endmodule

// ===== rtl/irst_datapath.sv =====
// ----------------------------------------------------------------------------
// irst_datapath
// Configuration, counters, debounce, period and light state, result register.
// ----------------------------------------------------------------------------
module irst_datapath
  import irst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sensor_level,
  input  cmd_t                   cmd,
  output status_t                st,
  output logic                   light_on,
  output logic                   ir_active
);

  // configuration registers
  logic [7:0]        debounce_limit;
  logic [7:0]        frame_divisor;
  logic [7:0]        period_offset;
  logic [7:0]        on_duty_ticks;
  logic [CEIL_W-1:0] counter_ceiling;

  // timer state
  logic [COUNT_WIDTH-1:0] strobe_count;
  logic [COUNT_WIDTH-1:0] pulse_length;
  logic [COUNT_WIDTH-1:0] strobe_period;
  logic [COUNT_WIDTH-1:0] mismatch_count;
  logic                   ir_state;
  logic                   light_state;
  logic                   need_quot;
  logic                   on_hit;
  logic                   per_hit;
  div_op_t                div_op;

  logic [COUNT_WIDTH-1:0] mismatch_inc;
  logic                   flip;
  logic [COUNT_WIDTH-1:0] on_div;
  logic                   div_done;
  logic [COUNT_WIDTH-1:0] div_quot;
  logic [COUNT_WIDTH-1:0] div_rem;
  logic [COUNT_WIDTH-1:0] div_dividend;
  logic [COUNT_WIDTH-1:0] div_divisor;
  logic                   light_next;
  logic [COUNT_WIDTH-1:0] count_fin;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit  <= 8'(DEBOUNCE_RESET);
      frame_divisor   <= 8'(FRAMES_RESET);
      period_offset   <= 8'(OFFSET_RESET);
      on_duty_ticks   <= 8'(ON_DUTY_RESET);
      counter_ceiling <= CEIL_W'(CEILING_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE_LIMIT:  debounce_limit  <= cfg_data[7:0];
        CFG_FRAMES_PER_EVT:  frame_divisor   <= cfg_data[7:0];
        CFG_PERIOD_OFFSET:   period_offset   <= cfg_data[7:0];
        CFG_ON_DUTY_TICKS:   on_duty_ticks   <= cfg_data[7:0];
        CFG_COUNTER_CEILING: counter_ceiling <= cfg_data[CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  // debounce decision for this tick
  assign mismatch_inc = mismatch_count + 1'b1;
  assign flip = (ir_state != sensor_level) &&
                (mismatch_inc > COUNT_WIDTH'(debounce_limit));

  // divisor of the turn-on test
  assign on_div = strobe_period - COUNT_WIDTH'(on_duty_ticks);

  // operand selection for the shared divider
  always_comb begin
    case (cmd.div_op)
      DIV_QUOT: begin
        div_dividend = pulse_length;
        div_divisor  = COUNT_WIDTH'(frame_divisor);
      end
      DIV_ON: begin
        div_dividend = strobe_count;
        div_divisor  = on_div;
      end
      DIV_PER: begin
        div_dividend = strobe_count;
        div_divisor  = strobe_period;
      end
      default: begin
        div_dividend = strobe_count;
        div_divisor  = strobe_period;
      end
    endcase
  end

  irst_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // end-of-tick light and counter values
  always_comb begin
    light_next = light_state;
    count_fin  = strobe_count;
    if (on_hit) begin
      light_next = 1'b1;
    end
    if (per_hit) begin
      light_next = 1'b0;
      count_fin  = '0;
    end
    if (CMP_W'(count_fin) >= CMP_W'(counter_ceiling)) begin
      count_fin = '0;
    end
  end

  // timer state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_count   <= '0;
      pulse_length   <= '0;
      strobe_period  <= COUNT_WIDTH'(PERIOD_RESET);
      mismatch_count <= '0;
      ir_state       <= 1'b0;
      light_state    <= 1'b0;
      need_quot      <= 1'b0;
      on_hit         <= 1'b0;
      per_hit        <= 1'b0;
      div_op         <= DIV_QUOT;
      light_on       <= 1'b0;
      ir_active      <= 1'b0;
    end else begin
      if (cmd.tick) begin
        strobe_count <= strobe_count + 1'b1;
        pulse_length <= pulse_length + 1'b1;
        on_hit       <= 1'b0;
        per_hit      <= 1'b0;
        need_quot    <= 1'b0;
        if (flip) begin
          mismatch_count <= '0;
          ir_state       <= sensor_level;
          if (!sensor_level) begin
            // zero divisor saturates the quotient to all ones
            if (frame_divisor == 8'd0) begin
              strobe_period <= {COUNT_WIDTH{1'b1}} + COUNT_WIDTH'(period_offset);
              pulse_length  <= '0;
            end else begin
              need_quot <= 1'b1;
            end
          end
        end else if (ir_state != sensor_level) begin
          mismatch_count <= mismatch_inc;
        end
      end
      if (cmd.div_start) begin
        div_op <= cmd.div_op;
      end
      // take the divider result
      if (cmd.div_capture) begin
        case (div_op)
          DIV_QUOT: begin
            strobe_period <= div_quot + COUNT_WIDTH'(period_offset);
            pulse_length  <= '0;
          end
          DIV_ON:  on_hit  <= (div_rem == '0);
          DIV_PER: per_hit <= (div_rem == '0);
          default: ;
        endcase
      end
      // close the tick and load the result register
      if (cmd.finish) begin
        light_state  <= light_next;
        strobe_count <= count_fin;
        light_on     <= light_next;
        ir_active    <= ir_state;
      end
    end
  end

  assign st.need_quot = need_quot;
  assign st.on_div_nz = (on_div != '0);
  assign st.period_nz = (strobe_period != '0);
  assign st.div_done  = div_done;

endmodule

// ===== rtl/irst_ctrl.sv =====
// ----------------------------------------------------------------------------
// irst_ctrl
// Sequencer of one tick: debounce, up to three divisions, result transfer.
// ----------------------------------------------------------------------------
module irst_ctrl
  import irst_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // result register can take a new value
  assign out_free = !out_valid || !out_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    cmd.tick        = 1'b0;
    cmd.div_start   = 1'b0;
    cmd.div_op      = DIV_QUOT;
    cmd.div_capture = 1'b0;
    cmd.finish      = 1'b0;
    in_stall        = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.tick   = 1'b1;
          state_next = ST_START_Q;
        end
      end
      ST_START_Q: begin
        if (st.need_quot) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_QUOT;
          state_next    = ST_WAIT_Q;
        end else begin
          state_next = ST_START_ON;
        end
      end
      ST_WAIT_Q: begin
        cmd.div_op = DIV_QUOT;
        if (st.div_done) begin
          cmd.div_capture = 1'b1;
          state_next      = ST_START_ON;
        end
      end
      ST_START_ON: begin
        cmd.div_op = DIV_ON;
        if (st.on_div_nz) begin
          cmd.div_start = 1'b1;
          state_next    = ST_WAIT_ON;
        end else begin
          state_next = ST_START_PER;
        end
      end
      ST_WAIT_ON: begin
        cmd.div_op = DIV_ON;
        if (st.div_done) begin
          cmd.div_capture = 1'b1;
          state_next      = ST_START_PER;
        end
      end
      ST_START_PER: begin
        cmd.div_op = DIV_PER;
        if (st.period_nz) begin
          cmd.div_start = 1'b1;
          state_next    = ST_WAIT_PER;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_WAIT_PER: begin
        cmd.div_op = DIV_PER;
        if (st.div_done) begin
          cmd.div_capture = 1'b1;
          state_next      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ir_synced_strobe_timer.sv =====
// ----------------------------------------------------------------------------
// ir_synced_strobe_timer
// Strobe light timer kept in step with a debounced IR sync signal.
// ----------------------------------------------------------------------------
// Each input transfer is one tick with the raw IR level; each tick yields one
// result transfer with the light level and the debounced IR state. The
// turn-on and turn-off tests each run a modulo, unless its divisor is zero,
// on one shared iterative divider that resolves 2 bits a cycle, and a
// debounced falling edge adds a third division for the new period unless
// the frames-per-event divisor is zero. The result sits in an output
// register, so the next tick is taken while it waits; the tick after that
// waits for its transfer. Configuration is written through the cfg channel,
// which is always ready.
// ----------------------------------------------------------------------------
module ir_synced_strobe_timer
  import irst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   sensor_level,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   light_on,
  output logic                   ir_active,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t st;

  // configuration writes are always accepted
  assign cfg_ready = 1'b1;

  irst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  irst_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sensor_level (sensor_level),
    .cmd          (cmd),
    .st           (st),
    .light_on     (light_on),
    .ir_active    (ir_active)
  );

  // an accepted tick blocks the input until it completes
  a_tick_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a tick was in progress");

  // a pending result is never overwritten
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result register overwritten before transfer");

  // the modulo divisors are never zero
  a_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_start && cmd.div_op == DIV_ON) |-> st.on_div_nz)
    else $error("turn-on modulo started with zero divisor");

  a_nonzero_period: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_start && cmd.div_op == DIV_PER) |-> st.period_nz)
    else $error("period modulo started with zero divisor");

endmodule
